@@ rtl/mie_pkg.sv @@
// shared types and constants for the modular inverse block
// no dependencies; used by every file under rtl
package mie_pkg;

  localparam int WIDTH = 64;
  localparam int KW = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [KW-1:0] shift_t;

  // result of the shared compare/subtract unit
  typedef struct packed {
    logic  ge;
    word_t diff;
  } cmp_t;

endpackage

@@ rtl/mie_cmpsub.sv @@
// shared compare and subtract unit: a >= b and a - b
// depends on mie_pkg
module mie_cmpsub (
  input  mie_pkg::word_t a,
  input  mie_pkg::word_t b,
  output mie_pkg::cmp_t  res
);

  logic [mie_pkg::WIDTH:0] d;

  always_comb begin
    d = {1'b0, a} - {1'b0, b};
    res.ge = ~d[mie_pkg::WIDTH];
    res.diff = d[mie_pkg::WIDTH-1:0];
  end

endmodule

@@ rtl/mie_modadd.sv @@
// shared modular adder: (x + y) mod m for x < m and y <= m
// depends on mie_pkg
module mie_modadd (
  input  mie_pkg::word_t x,
  input  mie_pkg::word_t y,
  input  mie_pkg::word_t m,
  output mie_pkg::word_t sum
);

  logic [mie_pkg::WIDTH:0] s;
  logic [mie_pkg::WIDTH:0] sm;

  always_comb begin
    s = {1'b0, x} + {1'b0, y};
    sm = s - {1'b0, m};
    sum = (s >= {1'b0, m}) ? sm[mie_pkg::WIDTH-1:0] : s[mie_pkg::WIDTH-1:0];
  end

endmodule

@@ rtl/modular_inverse_euclid.sv @@
// modular inverse by the extended euclidean algorithm, top level and sequencer
// depends on mie_pkg, mie_cmpsub, mie_modadd
//
//   channel  direction  signals
//   in       input      in_valid, in_stall, modulus, value
//   out      output     out_valid, out_stall, inverse, has_inverse
//
// one transaction at a time; in_stall is high from acceptance until the result is loaded
// a run is an initial reduction of value mod modulus, then euclid steps of align, divide,
// negate and update; the divide loop gives one quotient bit per cycle, except that in the
// euclid steps each set quotient bit adds an add state, and it shares one compare/subtract
// unit and one modular adder
// rst is synchronous and clears the sequencer and out_valid
// a stalled result holds in the output register; the next transaction may start meanwhile
module modular_inverse_euclid (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mie_pkg::word_t modulus,
  input  mie_pkg::word_t value,
  output logic           out_valid,
  input  logic           out_stall,
  output mie_pkg::word_t inverse,
  output logic           has_inverse
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALIGN = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_EU    = 4'd4;
  localparam logic [3:0] S_NEG   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0]      state;
  mie_pkg::word_t  mreg, r0, r1, t0, t1, rem, ds, acc, res_inv;
  mie_pkg::shift_t k;
  logic            eu, last, res_ok;

  mie_pkg::word_t cs_a, cs_b, ma_x, ma_y, ma_sum;
  mie_pkg::cmp_t  cs;
  logic           can_shift;
  logic           load_out;

  always_comb begin
    cs_a = rem;
    cs_b = ds;
    ma_x = acc;
    ma_y = acc;
    unique case (state)
      S_ALIGN: cs_b = {ds[mie_pkg::WIDTH-2:0], 1'b0};
      S_NEG: begin
        cs_a = mreg;
        cs_b = acc;
      end
      default: ;
    endcase
    unique case (state)
      S_ADD: ma_y = t1;
      S_UPD: begin
        ma_x = t0;
        ma_y = acc;
      end
      default: ;
    endcase
  end

  mie_cmpsub u_cmpsub (.a(cs_a), .b(cs_b), .res(cs));
  mie_modadd u_modadd (.x(ma_x), .y(ma_y), .m(mreg), .sum(ma_sum));

  assign can_shift = ~ds[mie_pkg::WIDTH-1] & cs.ge;
  assign in_stall = (state != S_IDLE);
  // result register is free or being emptied this cycle
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mreg <= modulus;
            rem <= value;
            ds <= modulus;
            k <= '0;
            eu <= 1'b0;
            res_inv <= '0;
            res_ok <= 1'b0;
            if (modulus < mie_pkg::word_t'(2) || value == '0) state <= S_FIN;
            else state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (can_shift) begin
            ds <= {ds[mie_pkg::WIDTH-2:0], 1'b0};
            k <= k + mie_pkg::shift_t'(1);
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // quotient bit msb first; horner doubling runs alongside
          if (cs.ge) rem <= cs.diff;
          acc <= ma_sum;
          last <= (k == '0);
          if (k != '0) begin
            ds <= {1'b0, ds[mie_pkg::WIDTH-1:1]};
            k <= k - mie_pkg::shift_t'(1);
          end
          if (cs.ge && eu) state <= S_ADD;
          else if (k == '0) state <= eu ? S_NEG : S_EU;
          if (k == '0 && !eu) begin
            // reduction done: set up the euclid loop
            r0 <= mreg;
            r1 <= cs.ge ? cs.diff : rem;
            t0 <= '0;
            t1 <= mie_pkg::word_t'(1);
            eu <= 1'b1;
          end
        end
        S_ADD: begin
          acc <= ma_sum;
          state <= last ? S_NEG : S_DIV;
        end
        S_EU: begin
          if (r1 == '0) begin
            if (r0 == mie_pkg::word_t'(1)) begin
              res_inv <= t0;
              res_ok <= 1'b1;
            end
            state <= S_FIN;
          end else begin
            rem <= r0;
            ds <= r1;
            k <= '0;
            acc <= '0;
            state <= S_ALIGN;
          end
        end
        S_NEG: begin
          // m - acc; acc of zero gives m, which the adder folds back to t0
          acc <= cs.diff;
          state <= S_UPD;
        end
        S_UPD: begin
          r0 <= r1;
          r1 <= rem;
          t0 <= t1;
          t1 <= ma_sum;
          state <= S_EU;
        end
        S_FIN: begin
          if (load_out) begin
            inverse <= res_inv;
            has_inverse <= res_ok;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_flag_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_inverse |-> inverse != '0)
    else $error("inverse flagged but zero");

  a_noflag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_inverse |-> inverse == '0)
    else $error("no inverse but nonzero result");

  a_rem_order: assert property (@(posedge clk) disable iff (rst)
    state == S_EU |-> r1 < r0)
    else $error("remainder sequence not decreasing");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    eu && (state == S_DIV || state == S_ADD) |-> acc < mreg)
    else $error("cofactor product out of range");

endmodule

@@ tb/sv/tb_modular_inverse_euclid.sv @@
// self-checking testbench for modular_inverse_euclid: directed and random operand pairs
// a queue-fed driver, a stalling monitor and a scoreboard holding predicted inverses
// depends on mie_pkg and the modular_inverse_euclid rtl
module tb_modular_inverse_euclid;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 1000;
  localparam mie_pkg::word_t ALL_ONES = '1;
  localparam mie_pkg::word_t PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64 - 59

  typedef struct packed {
    mie_pkg::word_t m;
    mie_pkg::word_t a;
  } operands_t;

  typedef struct packed {
    mie_pkg::word_t inverse;
    logic           has_inverse;
  } inverse_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  mie_pkg::word_t modulus = '0;
  mie_pkg::word_t value = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  mie_pkg::word_t inverse;
  logic           has_inverse;

  operands_t      pending_operands[$];
  inverse_t       expected_inverses[$];
  mie_pkg::word_t fib[$];

  logic      in_taken = 1'b0;
  logic      out_taken = 1'b0;
  int        in_gap = 0;
  int        out_hold = 2;
  bit        steady_in = 1'b0;
  bit        steady_out = 1'b0;
  int        errors = 0;
  int        idle_cycles = 0;
  operands_t next_operands;

  modular_inverse_euclid i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .modulus    (modulus),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inverse    (inverse),
    .has_inverse(has_inverse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // extended euclid with the cofactor kept reduced mod m
  function automatic inverse_t predict_inverse(mie_pkg::word_t m, mie_pkg::word_t a);
    inverse_t       res;
    mie_pkg::word_t r0, r1, t0, t1, q, rn, tn, qt;
    logic [127:0]   prod;
    res = '0;
    if (m < mie_pkg::word_t'(2)) return res;
    a = a % m;
    if (a == '0) return res;
    r0 = m;
    r1 = a;
    t0 = '0;
    t1 = mie_pkg::word_t'(1);
    while (r1 != '0) begin
      q = r0 / r1;
      rn = r0 % r1;
      prod = {64'd0, q} * {64'd0, t1};
      qt = mie_pkg::word_t'(prod % {64'd0, m});
      tn = (t0 >= qt) ? (t0 - qt) : (t0 + (m - qt));
      r0 = r1;
      r1 = rn;
      t0 = t1;
      t1 = tn;
    end
    if (r0 == mie_pkg::word_t'(1)) begin
      res.inverse = t0;
      res.has_inverse = 1'b1;
    end
    return res;
  endfunction

  function automatic mie_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // random word of a random bit length, so small and large magnitudes both show up
  function automatic mie_pkg::word_t rand_sized(int max_bits);
    int n;
    n = $urandom_range(1, max_bits);
    return rand_word() & (ALL_ONES >> (64 - n));
  endfunction

  task automatic add_operands(mie_pkg::word_t m, mie_pkg::word_t a);
    operands_t op;
    op.m = m;
    op.a = a;
    pending_operands.push_back(op);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // payload held until the transaction goes through
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_operands.size() > 0) begin
      next_operands = pending_operands.pop_front();
      modulus <= next_operands.m;
      value <= next_operands.a;
      in_valid <= 1'b1;
      if ($urandom_range(0, 63) == 0) steady_in = !steady_in;
      in_gap <= steady_in ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output stall: drawn per result, raised ahead of out_valid so the first cycle can stall too
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 63) == 0) steady_out = !steady_out;
      out_hold = steady_out ? 0 : $urandom_range(0, 4);
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_valid) begin
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold = out_hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= (out_hold > 0);
    end
  end

  // scoreboard: sample both channels on the rising edge
  always @(posedge clk) begin
    inverse_t exp_res;
    if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          errors++;
          $display("%0t: unexpected result inverse %h has_inverse %b",
                   $time, inverse, has_inverse);
        end else begin
          exp_res = expected_inverses.pop_front();
          if (inverse !== exp_res.inverse) begin
            errors++;
            $display("%0t: inverse mismatch, expected %h, actual %h",
                     $time, exp_res.inverse, inverse);
          end
          if (has_inverse !== exp_res.has_inverse) begin
            errors++;
            $display("%0t: has_inverse mismatch, expected %b, actual %b",
                     $time, exp_res.has_inverse, has_inverse);
          end
        end
      end
      if (in_valid && !in_stall) expected_inverses.push_back(predict_inverse(modulus, value));
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [64:0]    fsum;
    mie_pkg::word_t f_prev, f_cur, g, m, a;
    int             k, kind, idx;

    // fibonacci pairs give the longest remainder sequences
    f_prev = mie_pkg::word_t'(1);
    f_cur = mie_pkg::word_t'(1);
    fib.push_back(f_prev);
    fsum = {1'b0, f_prev} + {1'b0, f_cur};
    while (!fsum[64]) begin
      fib.push_back(f_cur);
      f_prev = f_cur;
      f_cur = fsum[63:0];
      fsum = {1'b0, f_prev} + {1'b0, f_cur};
    end
    fib.push_back(f_cur);

    // directed corners
    add_operands(64'd2, 64'd1);
    add_operands(64'd2, 64'd0);
    add_operands(64'd3, 64'd2);
    add_operands(ALL_ONES, ALL_ONES);
    add_operands(ALL_ONES, ALL_ONES - 1);
    add_operands(ALL_ONES, 64'd1);
    add_operands(ALL_ONES, 64'd0);
    add_operands(ALL_ONES, 64'h8000_0000_0000_0000);
    add_operands(ALL_ONES - 1, ALL_ONES);
    add_operands(64'd0, 64'd5);
    add_operands(64'd1, 64'd7);
    add_operands(64'd0, 64'd0);
    add_operands(64'd1, ALL_ONES);
    add_operands(64'd12, 64'd8);
    add_operands(64'd10, 64'd25);
    add_operands(64'd7, 64'd100);
    add_operands(64'd17, 64'd34);
    add_operands(64'd17, 64'd17);
    add_operands(64'd5, 64'd1);
    add_operands(64'd100, 64'd99);
    add_operands(PRIME_64, 64'd2);
    add_operands(PRIME_64, ALL_ONES);
    add_operands(64'h8000_0000_0000_0000, 64'd3);
    add_operands(fib[fib.size()-1], fib[fib.size()-2]);
    add_operands(fib[fib.size()-2], fib[fib.size()-1]);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          m = rand_word();
          a = rand_word();
        end
        2: begin
          m = rand_sized(64);
          a = rand_word();
        end
        3, 4: begin
          m = rand_sized(64);
          a = rand_sized(64);
        end
        5: begin
          // multiples of the modulus, wrap allowed
          m = rand_sized(32);
          a = m * mie_pkg::word_t'($urandom_range(0, 1000));
        end
        6: begin
          // shared factor
          g = mie_pkg::word_t'($urandom_range(2, 1000));
          m = g * rand_sized(50);
          a = g * rand_sized(50);
        end
        7: begin
          idx = $urandom_range(2, fib.size() - 1);
          m = fib[idx];
          a = fib[idx-1];
        end
        8: begin
          m = PRIME_64;
          a = rand_word();
        end
        default: begin
          m = ($urandom_range(0, 3) == 0) ? mie_pkg::word_t'($urandom_range(0, 1))
                                          : rand_sized(16);
          a = rand_sized(20);
        end
      endcase
      add_operands(m, a);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_operands.size() > 0 || in_valid || expected_inverses.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_inverses.size() != 0) errors++;
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
